FILE: rtl/core/vorticity_confinement_step_macros.svh
// Assertion macros for the vorticity confinement step block.
// Used by the top level only; expects clk_i and rst_ni in scope.
`ifndef VORTICITY_CONFINEMENT_STEP_MACROS_SVH
`define VORTICITY_CONFINEMENT_STEP_MACROS_SVH
`ifndef SYNTHESIS
`define VCS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define VCS_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define VCS_ASSERT(lbl, prop, msg)
`define VCS_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

FILE: rtl/core/vcs_pkg.sv
// Shared types, constants and helpers for the vorticity confinement step.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package vcs_pkg;
  localparam int WORD_W      = 32;
  localparam int FRAC_W      = 20;
  localparam int RAD_W       = 2 * WORD_W;
  localparam int ROOT_W      = WORD_W;
  localparam int SQRT_STAGES = ROOT_W;
  localparam int QUO_W       = FRAC_W + 1;
  localparam int DIV_STAGES  = QUO_W;
  localparam int UNIT_W      = QUO_W + 1;
  localparam int LINE_LEN    = SQRT_STAGES + DIV_STAGES;
  // input reg, five front stages, delay line, three back stages
  localparam int PIPE_LAT    = 6 + LINE_LEN + 3;
  localparam int IDX_W       = 8;

  typedef enum logic [IDX_W-1:0] {
    CFG_PASS_MODE = 8'd0,
    CFG_GAIN      = 8'd1,
    CFG_THRESH    = 8'd2,
    CFG_LIMIT     = 8'd3
  } cfg_idx_e;

  typedef struct packed {
    logic signed [WORD_W-1:0] vx;
    logic signed [WORD_W-1:0] vy;
    logic signed [WORD_W-1:0] zc;
    logic signed [WORD_W-1:0] curl;
    logic                     edge_c;
    logic                     sx;
    logic                     sy;
    logic [WORD_W-1:0]        mx;
    logic [WORD_W-1:0]        my;
    logic                     pass;
  } carry_t;

  function automatic logic [WORD_W-1:0] abs_w(input logic signed [WORD_W-1:0] v);
    abs_w = v[WORD_W-1] ? (~v + 1'b1) : v;
  endfunction
endpackage
`default_nettype wire

FILE: rtl/core/vorticity_confinement_step.sv
// Vorticity confinement stencil kernel, top level; one grid cell per transfer.
// Depends on vcs_pkg, vcs_isqrt, vcs_div and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "vorticity_confinement_step_macros.svh"
// One cell enters per clock (busy_o never rises). Its result sits on the
// outputs, marked by valid_o, in the order of the start transfers. The
// receiver cannot stall, so there is no back pressure anywhere. The latency
// is set by the 32-stage square root pipeline and the 21-stage normalizing
// divider; both passes take the same path so results never reorder. Config
// writes are always taken (cfg_ready_o high) and must only happen with the
// pipe empty.
module vorticity_confinement_step
  import vcs_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  output logic                          busy_o,
  input  wire logic                     cfg_valid_i,
  output logic                          cfg_ready_o,
  input  wire logic [IDX_W-1:0]         cfg_index_i,
  input  wire logic [WORD_W-1:0]        cfg_data_i,
  input  wire logic                     row_edge_i,
  input  wire logic                     col_edge_i,
  input  wire logic signed [WORD_W-1:0] nb_left_i,
  input  wire logic signed [WORD_W-1:0] nb_right_i,
  input  wire logic signed [WORD_W-1:0] nb_up_i,
  input  wire logic signed [WORD_W-1:0] nb_down_i,
  input  wire logic signed [WORD_W-1:0] curl_center_i,
  input  wire logic signed [WORD_W-1:0] vel_x_i,
  input  wire logic signed [WORD_W-1:0] vel_y_i,
  output logic                          valid_o,
  output logic signed [WORD_W-1:0]      curl_out_o,
  output logic signed [WORD_W-1:0]      new_vel_x_o,
  output logic signed [WORD_W-1:0]      new_vel_y_o,
  output logic                          force_applied_o
);
  // ---------------- configuration registers ----------------
  logic                     mode_q;
  logic signed [WORD_W-1:0] gain_q;
  logic [WORD_W-2:0]        thresh_q, limit_q;

  assign cfg_ready_o = 1'b1;
  assign busy_o      = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= 1'b0;
      gain_q   <= '0;
      thresh_q <= (WORD_W-1)'(1049);
      limit_q  <= (WORD_W-1)'(9437184);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_PASS_MODE: mode_q   <= cfg_data_i[0];
        CFG_GAIN:      gain_q   <= cfg_data_i;
        CFG_THRESH:    thresh_q <= cfg_data_i[WORD_W-2:0];
        CFG_LIMIT:     limit_q  <= cfg_data_i[WORD_W-2:0];
        default: ;
      endcase
    end
  end

  // ---------------- valid chain ----------------
  logic                vin_q, va_q, vb_q, vc_q, vd_q, ve_q, vf_q, vg_q, vout_q;
  logic [LINE_LEN-1:0] vline_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vin_q   <= 1'b0;
      va_q    <= 1'b0;
      vb_q    <= 1'b0;
      vc_q    <= 1'b0;
      vd_q    <= 1'b0;
      ve_q    <= 1'b0;
      vline_q <= '0;
      vf_q    <= 1'b0;
      vg_q    <= 1'b0;
      vout_q  <= 1'b0;
    end else begin
      vin_q   <= start_i && !busy_o;
      va_q    <= vin_q;
      vb_q    <= va_q;
      vc_q    <= vb_q;
      vd_q    <= vc_q;
      ve_q    <= vd_q;
      vline_q <= {vline_q[LINE_LEN-2:0], ve_q};
      vf_q    <= vline_q[LINE_LEN-1];
      vg_q    <= vf_q;
      vout_q  <= vg_q;
    end
  end

  // ---------------- input register ----------------
  logic                     redge_q, cedge_q;
  logic signed [WORD_W-1:0] left_q, right_q, up_q, down_q, zc_q, vx_q, vy_q;

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      redge_q <= row_edge_i;
      cedge_q <= col_edge_i;
      left_q  <= nb_left_i;
      right_q <= nb_right_i;
      up_q    <= nb_up_i;
      down_q  <= nb_down_i;
      zc_q    <= curl_center_i;
      vx_q    <= vel_x_i;
      vy_q    <= vel_y_i;
    end
  end

  // ---------------- stage A: differences and magnitudes ----------------
  carry_t                 ca_q, cb_q, cc_q, cd_q, ce_q;
  carry_t                 ca_d, cb_d, cc_d, ce_d;
  logic signed [WORD_W:0] dr_q, dv_q;
  logic [WORD_W-1:0]      al_q, ar_q, au_q, ad_q;

  always_comb begin
    ca_d        = '0;
    ca_d.vx     = vx_q;
    ca_d.vy     = vy_q;
    ca_d.zc     = zc_q;
    ca_d.edge_c = redge_q || cedge_q;
  end

  always_ff @(posedge clk_i) begin
    ca_q <= ca_d;
    dr_q <= cedge_q ? '0 : ({right_q[WORD_W-1], right_q} - {left_q[WORD_W-1], left_q});
    dv_q <= redge_q ? '0 : ({down_q[WORD_W-1], down_q} - {up_q[WORD_W-1], up_q});
    al_q <= abs_w(left_q);
    ar_q <= abs_w(right_q);
    au_q <= abs_w(up_q);
    ad_q <= abs_w(down_q);
  end

  // ---------------- stage B: curl, gradient of |curl| ----------------
  logic signed [WORD_W+1:0] diff, half;
  logic signed [WORD_W-1:0] curl_sat;
  logic signed [WORD_W:0]   dx_q, dy_q;

  always_comb begin
    diff = {dr_q[WORD_W], dr_q} - {dv_q[WORD_W], dv_q};
    half = diff >>> 1;
    if (half[WORD_W+1:WORD_W-1] == 3'b000 || half[WORD_W+1:WORD_W-1] == 3'b111) begin
      curl_sat = half[WORD_W-1:0];
    end else if (half[WORD_W+1]) begin
      curl_sat = {1'b1, {(WORD_W-1){1'b0}}};
    end else begin
      curl_sat = {1'b0, {(WORD_W-1){1'b1}}};
    end
    cb_d      = ca_q;
    cb_d.curl = curl_sat;
  end

  always_ff @(posedge clk_i) begin
    cb_q <= cb_d;
    dx_q <= {1'b0, ar_q} - {1'b0, al_q};
    dy_q <= {1'b0, ad_q} - {1'b0, au_q};
  end

  // ---------------- stage C: gradient magnitudes ----------------
  always_comb begin
    cc_d    = cb_q;
    cc_d.sx = dx_q[WORD_W];
    cc_d.sy = dy_q[WORD_W];
    cc_d.mx = dx_q[WORD_W] ? WORD_W'(-dx_q) : dx_q[WORD_W-1:0];
    cc_d.my = dy_q[WORD_W] ? WORD_W'(-dy_q) : dy_q[WORD_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    cc_q <= cc_d;
  end

  // ---------------- stage D: squares ----------------
  logic [RAD_W-1:0] sqx_q, sqy_q;

  always_ff @(posedge clk_i) begin
    cd_q  <= cc_q;
    sqx_q <= RAD_W'(cc_q.mx) * RAD_W'(cc_q.mx);
    sqy_q <= RAD_W'(cc_q.my) * RAD_W'(cc_q.my);
  end

  // ---------------- stage E: squared magnitude and threshold ----------------
  logic [RAD_W-1:0] s_sum, s_q;

  assign s_sum = sqx_q + sqy_q;

  always_comb begin
    ce_d      = cd_q;
    // squared gradient in Q.FRAC_W is S / 2^(FRAC_W+2)
    ce_d.pass = s_sum[RAD_W-1:FRAC_W+2] > (RAD_W-FRAC_W-2)'(thresh_q);
  end

  always_ff @(posedge clk_i) begin
    ce_q <= ce_d;
    s_q  <= s_sum;
  end

  // ---------------- root, normalizing divides, delay line ----------------
  carry_t            line_q [LINE_LEN];
  logic [ROOT_W-1:0] root;
  logic [QUO_W-1:0]  qx, qy;

  always_ff @(posedge clk_i) begin
    line_q[0] <= ce_q;
    for (int i = 1; i < LINE_LEN; i++) begin
      line_q[i] <= line_q[i-1];
    end
  end

  vcs_isqrt u_isqrt (
    .clk_i  (clk_i),
    .rad_i  (s_q),
    .root_o (root)
  );

  vcs_div u_div_x (
    .clk_i (clk_i),
    .num_i (line_q[SQRT_STAGES-1].mx),
    .den_i (root),
    .quo_o (qx)
  );

  vcs_div u_div_y (
    .clk_i (clk_i),
    .num_i (line_q[SQRT_STAGES-1].my),
    .den_i (root),
    .quo_o (qy)
  );

  // ---------------- stage F: gain times unit vector ----------------
  carry_t                        cl, cf_q, cg_q;
  logic signed [UNIT_W-1:0]      ux, uy;
  logic signed [WORD_W+UNIT_W-1:0] px_q, py_q;

  assign cl = line_q[LINE_LEN-1];
  assign ux = cl.sx ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
  assign uy = cl.sy ? -$signed({1'b0, qy}) : $signed({1'b0, qy});

  always_ff @(posedge clk_i) begin
    cf_q <= cl;
    px_q <= gain_q * ux;
    py_q <= gain_q * uy;
  end

  // ---------------- stage G: force times center curl ----------------
  localparam int FW = WORD_W + UNIT_W - FRAC_W;
  logic signed [FW-1:0]        fx, fy;
  logic signed [FW+WORD_W-1:0] pvx_q, pvy_q;

  assign fx = px_q[WORD_W+UNIT_W-1:FRAC_W];
  assign fy = py_q[WORD_W+UNIT_W-1:FRAC_W];

  always_ff @(posedge clk_i) begin
    cg_q  <= cf_q;
    pvx_q <= fy * cf_q.zc;
    pvy_q <= fx * cf_q.zc;
  end

  // ---------------- stage H: update, clamp, select ----------------
  localparam int TW = FW + WORD_W - FRAC_W;
  logic signed [TW:0]        nx, ny, lim, nlim;
  logic signed [WORD_W-1:0]  cx, cy;
  logic                      apply;

  always_comb begin
    lim  = $signed({{(TW+2-WORD_W){1'b0}}, limit_q});
    nlim = -lim;
    nx = $signed({{(TW+1-WORD_W){cg_q.vx[WORD_W-1]}}, cg_q.vx})
       + $signed({pvx_q[FW+WORD_W-1], pvx_q[FW+WORD_W-1:FRAC_W]});
    ny = $signed({{(TW+1-WORD_W){cg_q.vy[WORD_W-1]}}, cg_q.vy})
       - $signed({pvy_q[FW+WORD_W-1], pvy_q[FW+WORD_W-1:FRAC_W]});
    // limit is below 2^31, so the clamped value always fits the word
    if (nx > lim) begin
      cx = lim[WORD_W-1:0];
    end else if (nx < nlim) begin
      cx = nlim[WORD_W-1:0];
    end else begin
      cx = nx[WORD_W-1:0];
    end
    if (ny > lim) begin
      cy = lim[WORD_W-1:0];
    end else if (ny < nlim) begin
      cy = nlim[WORD_W-1:0];
    end else begin
      cy = ny[WORD_W-1:0];
    end
    apply = mode_q && !cg_q.edge_c && cg_q.pass;
  end

  always_ff @(posedge clk_i) begin
    curl_out_o      <= mode_q ? '0 : cg_q.curl;
    new_vel_x_o     <= apply ? cx : cg_q.vx;
    new_vel_y_o     <= apply ? cy : cg_q.vy;
    force_applied_o <= apply;
  end

  assign valid_o = vout_q;

  // ---------------- assertions ----------------
  `VCS_ASSERT(a_fixed_latency, start_i && !busy_o |-> ##PIPE_LAT valid_o,
              "result did not appear after pipeline latency")
  `VCS_ASSERT(a_force_mode, force_applied_o && valid_o |-> mode_q && curl_out_o == '0,
              "force applied outside apply pass")
  `VCS_ASSERT_NEVER(a_clamp, valid_o && force_applied_o &&
                    ($signed(new_vel_x_o) > $signed({1'b0, limit_q}) ||
                     $signed(new_vel_x_o) < -$signed({1'b0, limit_q}) ||
                     $signed(new_vel_y_o) > $signed({1'b0, limit_q}) ||
                     $signed(new_vel_y_o) < -$signed({1'b0, limit_q})),
                    "updated velocity outside limit")
endmodule
`default_nettype wire

FILE: rtl/core/vcs_isqrt.sv
// Pipelined integer square root, one root bit per stage, floor result.
// Depends on vcs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module vcs_isqrt
  import vcs_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic [RAD_W-1:0]  rad_i,
  output logic      [ROOT_W-1:0] root_o
);
  logic [RAD_W-1:0]  rad_q  [SQRT_STAGES];
  logic [ROOT_W-1:0] root_q [SQRT_STAGES];
  logic [ROOT_W+1:0] rem_q  [SQRT_STAGES];

  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
    logic [RAD_W-1:0]  rad_p;
    logic [ROOT_W-1:0] root_p;
    logic [ROOT_W+1:0] rem_p;
    logic [ROOT_W+3:0] cur, trial;
    logic              ge;
    if (k == 0) begin : g_first
      assign rad_p  = rad_i;
      assign root_p = '0;
      assign rem_p  = '0;
    end else begin : g_rest
      assign rad_p  = rad_q[k-1];
      assign root_p = root_q[k-1];
      assign rem_p  = rem_q[k-1];
    end
    always_comb begin
      cur   = {rem_p, rad_p[RAD_W-1 -: 2]};
      trial = {2'b00, root_p, 2'b01};
      ge    = cur >= trial;
    end
    always_ff @(posedge clk_i) begin
      rad_q[k]  <= {rad_p[RAD_W-3:0], 2'b00};
      root_q[k] <= {root_p[ROOT_W-2:0], ge};
      rem_q[k]  <= ge ? (ROOT_W+2)'(cur - trial) : cur[ROOT_W+1:0];
    end
  end

  assign root_o = root_q[SQRT_STAGES-1];
endmodule
`default_nettype wire

FILE: rtl/core/vcs_div.sv
// Pipelined restoring divider: floor((num << FRAC_W) / den), one quotient bit per stage.
// Valid only when num <= den, so the quotient fits QUO_W bits. Depends on vcs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module vcs_div
  import vcs_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic [WORD_W-1:0] num_i,
  input  wire logic [ROOT_W-1:0] den_i,
  output logic      [QUO_W-1:0]  quo_o
);
  logic [ROOT_W-1:0] den_q [DIV_STAGES];
  logic [ROOT_W-1:0] par_q [DIV_STAGES];
  logic [QUO_W-1:0]  quo_q [DIV_STAGES];

  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_stage
    logic [ROOT_W-1:0] den_p, par_p;
    logic [QUO_W-1:0]  quo_p;
    logic              nbit;
    logic [ROOT_W:0]   cur;
    logic              ge;
    if (j == 0) begin : g_first
      assign den_p = den_i;
      assign par_p = {1'b0, num_i[WORD_W-1:1]};
      assign quo_p = '0;
      assign nbit  = num_i[0];
    end else begin : g_rest
      assign den_p = den_q[j-1];
      assign par_p = par_q[j-1];
      assign quo_p = quo_q[j-1];
      assign nbit  = 1'b0;
    end
    always_comb begin
      cur = {par_p, nbit};
      ge  = cur >= {1'b0, den_p};
    end
    always_ff @(posedge clk_i) begin
      den_q[j] <= den_p;
      par_q[j] <= ge ? ROOT_W'(cur - {1'b0, den_p}) : cur[ROOT_W-1:0];
      quo_q[j] <= {quo_p[QUO_W-2:0], ge};
    end
  end

  assign quo_o = quo_q[DIV_STAGES-1];
endmodule
`default_nettype wire

FILE: tb/testbench.sv
// Self-checking bench for vorticity_confinement_step: directed table, then random phases.
// Depends on vcs_pkg and the vorticity_confinement_step RTL; reads no files.
`timescale 1ns / 1ps

module testbench;
  import vcs_pkg::*;

  // Write to an index past the register list; the block must ignore it.
  localparam logic [IDX_W-1:0] CFG_IDX_UNMAPPED = 8'hC3;
  // Allow the pipeline latency plus slack for the final drain.
  localparam int DRAIN_CYCLES = PIPE_LAT + 8;
  localparam int QUIET_LIMIT  = 2000;
  localparam int RAND_PHASES  = 8;
  localparam int PHASE_CELLS  = 230;

  typedef struct {
    logic                     row_edge;
    logic                     col_edge;
    logic signed [WORD_W-1:0] left;
    logic signed [WORD_W-1:0] right;
    logic signed [WORD_W-1:0] up;
    logic signed [WORD_W-1:0] down;
    logic signed [WORD_W-1:0] zc;
    logic signed [WORD_W-1:0] vx;
    logic signed [WORD_W-1:0] vy;
  } cell_t;

  typedef struct {
    logic signed [WORD_W-1:0] curl;
    logic signed [WORD_W-1:0] vx;
    logic signed [WORD_W-1:0] vy;
    logic                     force_on;
  } vel_update_t;

  // Directed stimulus row: either a register write or a cell, with an
  // optional hand-typed expectation.
  typedef struct {
    bit                is_cfg;
    logic [IDX_W-1:0]  idx;
    logic [WORD_W-1:0] data;
    cell_t             item;
    bit                typed;
    vel_update_t       res;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic start_i, busy_o;
  logic cfg_valid_i, cfg_ready_o;
  logic [IDX_W-1:0] cfg_index_i;
  logic [WORD_W-1:0] cfg_data_i;
  logic row_edge_i, col_edge_i;
  logic signed [WORD_W-1:0] nb_left_i, nb_right_i, nb_up_i, nb_down_i;
  logic signed [WORD_W-1:0] curl_center_i, vel_x_i, vel_y_i;
  logic valid_o, force_applied_o;
  logic signed [WORD_W-1:0] curl_out_o, new_vel_x_o, new_vel_y_o;

  // Shadow copy of the configuration registers.
  bit                       mode_q;
  logic signed [WORD_W-1:0] gain_q;
  logic [30:0]              thresh_q;
  logic [30:0]              limit_q;

  vel_update_t pending_q[$];
  int          err_count;
  int          quiet_cycles;

  always #1 clk_i = ~clk_i;

  vorticity_confinement_step u_top (
    .clk_i, .rst_ni, .start_i, .busy_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .row_edge_i, .col_edge_i,
    .nb_left_i, .nb_right_i, .nb_up_i, .nb_down_i,
    .curl_center_i, .vel_x_i, .vel_y_i,
    .valid_o, .curl_out_o, .new_vel_x_o, .new_vel_y_o, .force_applied_o
  );

  // ---------------------------------------------------------------- predictor

  function automatic longint abs64(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic logic signed [WORD_W-1:0] sat_word(longint v);
    if (v > longint'(32'sh7FFF_FFFF)) return 32'sh7FFF_FFFF;
    if (v < -longint'(32'sh7FFF_FFFF) - 1) return 32'sh8000_0000;
    return v[WORD_W-1:0];
  endfunction

  // Bitwise integer square root, floor.
  function automatic logic [63:0] int_sqrt(logic [63:0] n);
    logic [63:0] root;
    logic [63:0] b;
    root = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= root + b) begin
        n    = n - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b >>= 2;
    end
    return root;
  endfunction

  // Signed unit-vector component: |d| / root in Q.FRAC_W, truncated.
  function automatic longint unit_comp(longint d, logic [63:0] root);
    logic [63:0] q;
    q = (64'(abs64(d)) << FRAC_W) / root;
    return (d < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic vel_update_t predict_update(cell_t c);
    vel_update_t r;
    longint      dr, dv, dx, dy, ux, uy, fx, fy, nx, ny, lim;
    logic [63:0] mx, my, s, root;
    r.curl     = '0;
    r.vx       = c.vx;
    r.vy       = c.vy;
    r.force_on = 1'b0;
    if (!mode_q) begin
      dr = c.col_edge ? 0 : longint'(c.right) - longint'(c.left);
      dv = c.row_edge ? 0 : longint'(c.down) - longint'(c.up);
      r.curl = sat_word((dr - dv) >>> 1);
      return r;
    end
    // edge cells pass straight through in the apply pass
    if (c.row_edge || c.col_edge) return r;
    dx = abs64(longint'(c.right)) - abs64(longint'(c.left));
    dy = abs64(longint'(c.down)) - abs64(longint'(c.up));
    mx = 64'(abs64(dx));
    my = 64'(abs64(dy));
    s  = mx * mx + my * my;
    if ((s >> (FRAC_W + 2)) <= 64'(thresh_q)) return r;
    root = int_sqrt(s);
    if (root == 0) return r;
    ux  = unit_comp(dx, root);
    uy  = unit_comp(dy, root);
    fx  = (longint'(gain_q) * ux) >>> FRAC_W;
    fy  = (longint'(gain_q) * uy) >>> FRAC_W;
    lim = longint'(limit_q);
    nx  = longint'(c.vx) + ((fy * longint'(c.zc)) >>> FRAC_W);
    ny  = longint'(c.vy) - ((fx * longint'(c.zc)) >>> FRAC_W);
    if (nx > lim) nx = lim;
    if (nx < -lim) nx = -lim;
    if (ny > lim) ny = lim;
    if (ny < -lim) ny = -lim;
    r.vx       = sat_word(nx);
    r.vy       = sat_word(ny);
    r.force_on = 1'b1;
    return r;
  endfunction

  function automatic void shadow_write(logic [IDX_W-1:0] idx, logic [WORD_W-1:0] data);
    case (idx)
      CFG_PASS_MODE: mode_q   = data[0];
      CFG_GAIN:      gain_q   = data;
      CFG_THRESH:    thresh_q = data[30:0];
      CFG_LIMIT:     limit_q  = data[30:0];
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------- drivers

  // Present a cell and hold it until the transfer; leaves start_i high so a
  // following call continues the burst without a bubble.
  task automatic send_cell(cell_t c, bit typed, vel_update_t typed_res);
    start_i       <= 1'b1;
    row_edge_i    <= c.row_edge;
    col_edge_i    <= c.col_edge;
    nb_left_i     <= c.left;
    nb_right_i    <= c.right;
    nb_up_i       <= c.up;
    nb_down_i     <= c.down;
    curl_center_i <= c.zc;
    vel_x_i       <= c.vx;
    vel_y_i       <= c.vy;
    do @(posedge clk_i); while (busy_o);
    pending_q.push_back(typed ? typed_res : predict_update(c));
  endtask

  task automatic hold_off(int n);
    start_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Pause until every expected result has come back; the pipe is then empty.
  task automatic drain_pipe();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  // One write, then the write channel idles before the task returns.
  task automatic write_reg(logic [IDX_W-1:0] idx, logic [WORD_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    shadow_write(idx, data);
    @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------- stimulus

  function automatic cell_t mk_cell(bit re, bit ce, logic [31:0] l, logic [31:0] rt,
                                    logic [31:0] u, logic [31:0] d, logic [31:0] z,
                                    logic [31:0] vx, logic [31:0] vy);
    cell_t c;
    c.row_edge = re; c.col_edge = ce;
    c.left = l; c.right = rt; c.up = u; c.down = d;
    c.zc = z; c.vx = vx; c.vy = vy;
    return c;
  endfunction

  function automatic stim_row_t checked_row(cell_t c);
    stim_row_t s;
    s = '{default: '0};
    s.item = c;
    return s;
  endfunction

  function automatic stim_row_t typed_row(cell_t c, logic [31:0] curl, bit force_on);
    stim_row_t s;
    s = checked_row(c);
    s.typed = 1'b1;
    s.res   = '{curl: curl, vx: c.vx, vy: c.vy, force_on: force_on};
    return s;
  endfunction

  function automatic stim_row_t cfg_row(logic [IDX_W-1:0] idx, logic [31:0] data);
    stim_row_t s;
    s = '{default: '0};
    s.is_cfg = 1'b1;
    s.idx    = idx;
    s.data   = data;
    return s;
  endfunction

  // Mix of full-range words, values within +-8.0, tiny values and extremes.
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 5))
      0, 1: return $urandom;
      2, 3: return 32'($urandom_range(0, 1 << 24)) - 32'(1 << 23);
      4: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'h0;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      default: return 32'($urandom_range(0, 2048)) - 32'd1024;
    endcase
  endfunction

  function automatic cell_t rand_cell();
    return mk_cell($urandom_range(0, 7) == 0, $urandom_range(0, 7) == 0,
                   pick_word(), pick_word(), pick_word(), pick_word(),
                   pick_word(), pick_word(), pick_word());
  endfunction

  stim_row_t dir_rows[$];

  initial begin
    cell_t       c;
    vel_update_t none;
    int          sent;
    int          burst;
    logic [31:0] gain_v, thresh_v, limit_v;

    none          = '{default: '0};
    err_count     = 0;
    rst_ni        <= 1'b0;
    start_i       <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= '0;
    cfg_data_i    <= '0;
    row_edge_i    <= 1'b0;
    col_edge_i    <= 1'b0;
    nb_left_i     <= '0;
    nb_right_i    <= '0;
    nb_up_i       <= '0;
    nb_down_i     <= '0;
    curl_center_i <= '0;
    vel_x_i       <= '0;
    vel_y_i       <= '0;
    mode_q        = 1'b0;
    gain_q        = '0;
    thresh_q      = 31'd1049;
    limit_q       = 31'd9437184;

    // Curl pass with reset registers: zero, both word extremes, saturation, floor of -1/2.
    dir_rows.push_back(typed_row(mk_cell(0, 0, 0, 0, 0, 0, 0, 32'h1234_5678,
                                         32'h8765_4321), 32'h0, 0));
    dir_rows.push_back(typed_row(mk_cell(0, 0, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0,
                                         0, 0, 0), 32'h7FFF_FFFF, 0));
    dir_rows.push_back(typed_row(mk_cell(0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0,
                                         0, 0, 0), 32'h8000_0000, 0));
    dir_rows.push_back(typed_row(mk_cell(0, 0, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF,
                                         0, 0, 0), 32'h8000_0000, 0));
    dir_rows.push_back(typed_row(mk_cell(0, 0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000,
                                         0, 0, 0), 32'h7FFF_FFFF, 0));
    dir_rows.push_back(typed_row(mk_cell(0, 0, 32'h8000_0000, 32'h7FFF_FFFF,
                                         32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0),
                                 32'h7FFF_FFFF, 0));
    dir_rows.push_back(typed_row(mk_cell(0, 0, 1, 0, 0, 0, 0, 0, 0), 32'hFFFF_FFFF, 0));
    // edge rows and columns drop one term each
    dir_rows.push_back(checked_row(mk_cell(1, 0, 32'h0010_0000, 32'h0050_0000,
                                           32'h0020_0000, 32'hFFF0_0000, 5, 6, 7)));
    dir_rows.push_back(checked_row(mk_cell(0, 1, 32'h0010_0000, 32'h0050_0000,
                                           32'h0020_0000, 32'hFFF0_0000, 5, 6, 7)));
    dir_rows.push_back(typed_row(mk_cell(1, 1, 32'h7FFF_FFFF, 32'h8000_0000,
                                         32'h1, 32'h2, 0, 3, 4), 32'h0, 0));

    // Apply pass with half gain and default threshold and clamp.
    dir_rows.push_back(cfg_row(CFG_PASS_MODE, 32'h1));
    dir_rows.push_back(cfg_row(CFG_GAIN, 32'h0008_0000));
    dir_rows.push_back(typed_row(mk_cell(1, 0, 32'h0040_0000, 32'h0, 32'h0, 32'h0,
                                         32'h0010_0000, 11, 12), 32'h0, 0));
    dir_rows.push_back(typed_row(mk_cell(0, 1, 32'h0040_0000, 32'h0, 32'h0, 32'h0,
                                         32'h0010_0000, 11, 12), 32'h0, 0));
    // threshold not reached: all zero, then equal magnitudes that cancel
    dir_rows.push_back(typed_row(mk_cell(0, 0, 0, 0, 0, 0, 32'h0010_0000,
                                         32'hFFFF_FFFF, 32'h7FFF_FFFF), 32'h0, 0));
    dir_rows.push_back(typed_row(mk_cell(0, 0, 32'hFFB0_0000, 32'h0050_0000,
                                         32'h0030_0000, 32'hFFD0_0000, 32'h0010_0000,
                                         32'h1, 32'h2), 32'h0, 0));
    dir_rows.push_back(checked_row(mk_cell(0, 0, 0, 32'h0020_0000, 0, 32'h0010_0000,
                                           32'h0010_0000, 32'h0008_0000, 32'h0)));
    dir_rows.push_back(checked_row(mk_cell(0, 0, 0, 32'h8000_0000, 0, 32'h8000_0000,
                                           32'h8000_0000, 32'h7FFF_FFFF,
                                           32'h8000_0000)));
    // zero clamp bound and zero threshold, extreme gain
    dir_rows.push_back(cfg_row(CFG_LIMIT, 32'h0));
    dir_rows.push_back(cfg_row(CFG_THRESH, 32'h0));
    dir_rows.push_back(cfg_row(CFG_GAIN, 32'h8000_0000));
    dir_rows.push_back(checked_row(mk_cell(0, 0, 32'h0000_0400, 0, 0, 32'h0000_0800,
                                           32'h0010_0000, 32'h0030_0000,
                                           32'hFFD0_0000)));
    dir_rows.push_back(cfg_row(CFG_IDX_UNMAPPED, 32'hFFFF_FFFF));
    dir_rows.push_back(checked_row(mk_cell(0, 0, 32'h7FFF_FFFF, 32'h1, 32'h8000_0000,
                                           32'h3, 32'h7FFF_FFFF, 32'h5, 32'h6)));

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        drain_pipe();
        write_reg(dir_rows[i].idx, dir_rows[i].data);
      end else begin
        send_cell(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].res);
        if ($urandom_range(0, 2) == 0) hold_off($urandom_range(1, 3));
      end
    end

    // Random phases, each with its own register setting; extremes come first.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0: begin gain_v = 32'h7FFF_FFFF; thresh_v = 32'h0;        limit_v = 32'h7FFF_FFFF; end
        1: begin gain_v = 32'h8000_0000; thresh_v = 32'h7FFF_FFFF; limit_v = 32'h0;        end
        2: begin gain_v = 32'h0;         thresh_v = 32'd1049;      limit_v = 32'd9437184;  end
        default: begin
          gain_v   = ($urandom_range(0, 1) == 0) ? $urandom
                     : 32'($urandom_range(0, 1 << 22)) - 32'(1 << 21);
          thresh_v = $urandom_range(0, 1 << 22);
          limit_v  = ($urandom_range(0, 1) == 0) ? {1'b0, 31'($urandom)}
                     : 32'($urandom_range(0, 1 << 24));
        end
      endcase
      drain_pipe();
      write_reg(CFG_PASS_MODE, (ph == 0) ? 32'h1 : 32'(ph % 2));
      write_reg(CFG_GAIN, gain_v);
      write_reg(CFG_THRESH, thresh_v);
      write_reg(CFG_LIMIT, limit_v);
      write_reg(CFG_IDX_UNMAPPED, $urandom);

      sent = 0;
      while (sent < PHASE_CELLS) begin
        burst = $urandom_range(1, 40);
        for (int k = 0; k < burst && sent < PHASE_CELLS; k++) begin
          c = rand_cell();
          send_cell(c, 1'b0, none);
          sent++;
        end
        // roughly a third of bursts run straight into the next one
        if ($urandom_range(0, 2) != 0) hold_off($urandom_range(1, 6));
      end
    end

    drain_pipe();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_q.size() != 0) begin
      $error("results missing: %0d still expected", pending_q.size());
      err_count++;
    end
    if (err_count == 0) begin
      $display("vorticity_confinement_step: match");
    end else begin
      $display("vorticity_confinement_step: mismatch");
    end
    $finish;
  end

  // ---------------------------------------------------------------- checking

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s: expected %h, got %h", name, exp_v, got_v);
      err_count++;
    end
  endtask

  always @(posedge clk_i) begin
    vel_update_t e;
    if (rst_ni && valid_o) begin
      if (pending_q.size() == 0) begin
        $error("result with nothing expected");
        err_count++;
      end else begin
        e = pending_q.pop_front();
        check_field("curl_out", e.curl, curl_out_o);
        check_field("new_vel_x", e.vx, new_vel_x_o);
        check_field("new_vel_y", e.vy, new_vel_y_o);
        check_field("force_applied", 32'(e.force_on), 32'(force_applied_o));
      end
    end
  end

  // Watchdog: cycles with no transfer on any channel.
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || valid_o || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("vorticity_confinement_step: mismatch");
      $finish;
    end
  end

  initial quiet_cycles = 0;

endmodule

FILE: vorticity_confinement_step.f
+incdir+rtl/core
rtl/core/vcs_pkg.sv
rtl/core/vcs_isqrt.sv
rtl/core/vcs_div.sv
rtl/core/vorticity_confinement_step.sv
tb/testbench.sv
